[hw/rtl/mfte_pkg.sv]
// ----------------------------------------------------------------------------
// mfte_pkg
// Shared constants, codes and types of the monochrome framebuffer text engine.
// ----------------------------------------------------------------------------
package mfte_pkg;

   // Panel geometry
   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int NUM_PAGES    = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_SIZE   = PANEL_WIDTH * NUM_PAGES;
   localparam int ADDR_W       = $clog2(STORE_SIZE);

   // Font and character limits
   localparam logic [4:0]  GLYPH_MAX     = 5'd16;
   localparam logic [4:0]  FONT_W_RESET  = 5'd7;
   localparam logic [4:0]  FONT_H_RESET  = 5'd10;
   localparam logic [7:0]  CHAR_FIRST    = 8'd32;   // ' '
   localparam logic [7:0]  CHAR_LAST     = 8'd126;  // '~'
   localparam logic [15:0] PIXEL_PATTERN = 16'h8000;
   localparam logic [7:0]  FILL_ON       = 8'hFF;
   localparam logic [7:0]  FILL_OFF      = 8'h00;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes of the configuration port
   localparam logic CSR_FONT_WIDTH  = 1'b0;
   localparam logic CSR_FONT_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ACT_FILL   = 3'd0,
      ACT_PIXEL  = 3'd1,
      ACT_CURSOR = 3'd2,
      ACT_GLYPH  = 3'd3,
      ACT_READ   = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      OP_FILL,
      OP_PLOT,
      OP_CURSOR,
      OP_READ,
      OP_REJECT,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  x;
      logic [7:0]  y;        // glyph: row offset from cursor_y
      logic        color;
      logic [15:0] pattern;
      logic [4:0]  count;    // pixels to plot
      logic        glyph;    // plot relative to the text cursor
      logic        advance;  // last glyph row: move cursor after drawing
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

[hw/rtl/mfte_front.sv]
// ----------------------------------------------------------------------------
// mfte_front
// Accepts requests and turns them into commands for the back end.
// ----------------------------------------------------------------------------
module mfte_front
   import mfte_pkg::*;
(
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [2:0]      req_action,
   input  logic [7:0]      req_x,
   input  logic [7:0]      req_y,
   input  logic            req_color,
   input  logic [7:0]      req_char_code,
   input  logic [3:0]      req_row_index,
   input  logic [15:0]     req_row_bits,
   input  logic [4:0]      font_width,
   input  logic [4:0]      font_height,
   input  logic            queue_full,
   input  back_status_type back_status,
   output logic            cmd_push,
   output cmd_type         cmd
);

   logic [4:0] fw_sat;
   logic [4:0] fh_sat;
   logic       last_row;
   logic       code_ok;
   logic       read_ok;

   assign fw_sat   = (font_width > GLYPH_MAX) ? GLYPH_MAX : font_width;
   assign fh_sat   = (font_height > GLYPH_MAX) ? GLYPH_MAX : font_height;
   assign last_row = (fh_sat != 5'd0) && ({1'b0, req_row_index} == (fh_sat - 5'd1));
   assign code_ok  = (req_char_code >= CHAR_FIRST) && (req_char_code <= CHAR_LAST);
   assign read_ok  = ({1'b0, req_x} < 9'(PANEL_WIDTH)) && ({1'b0, req_y} < 9'(NUM_PAGES));

   assign req_stall = queue_full | back_status.clearing;
   assign cmd_push  = req_valid & ~req_stall;

   always_comb begin
      cmd.op      = OP_NOP;
      cmd.x       = req_x;
      cmd.y       = req_y;
      cmd.color   = req_color;
      cmd.pattern = PIXEL_PATTERN;
      cmd.count   = 5'd1;
      cmd.glyph   = 1'b0;
      cmd.advance = 1'b0;
      unique case (action_type'(req_action))
         ACT_FILL: begin
            cmd.op = OP_FILL;
         end
         ACT_PIXEL: begin
            cmd.op = OP_PLOT;
         end
         ACT_CURSOR: begin
            cmd.op = OP_CURSOR;
         end
         ACT_GLYPH: begin
            cmd.op      = code_ok ? OP_PLOT : OP_REJECT;
            cmd.y       = {4'd0, req_row_index};
            cmd.pattern = req_row_bits;
            cmd.count   = fw_sat;
            cmd.glyph   = 1'b1;
            cmd.advance = last_row;
         end
         ACT_READ: begin
            cmd.op = read_ok ? OP_READ : OP_NOP;
         end
         default: begin
            cmd.op = OP_NOP;
         end
      endcase
   end

endmodule

[hw/rtl/mfte_cmd_queue.sv]
// ----------------------------------------------------------------------------
// mfte_cmd_queue
// Short command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mfte_cmd_queue
   import mfte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign empty   = (count_ff == QCNT_W'(0));
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                            : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                            : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hw/rtl/mfte_back.sv]
// ----------------------------------------------------------------------------
// mfte_back
// Executes commands against the frame store and the text cursor, and holds
// the response register.
// ----------------------------------------------------------------------------
module mfte_back
   import mfte_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         head,
   input  logic            queue_empty,
   output logic            queue_pop,
   output back_status_type back_status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_status,
   output logic [7:0]      rsp_cursor_x_out
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_PLOT,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   function automatic logic [ADDR_W-1:0] frame_addr(input logic [7:0] col,
                                                    input logic [7:0] page);
      logic [31:0] a;
      a = 32'(col) + 32'(page) * 32'(PANEL_WIDTH);
      return a[ADDR_W-1:0];
   endfunction

   // frame store
   logic [7:0]        mem [STORE_SIZE];
   logic [7:0]        rd_data_ff;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;

   state_type         state_ff, state_in;
   logic [7:0]        base_x_ff, base_x_in;
   logic [7:0]        py_ff, py_in;
   logic              color_ff, color_in;
   logic [15:0]       pattern_ff, pattern_in;
   logic [4:0]        count_ff, count_in;
   logic              adv_ff, adv_in;
   logic [4:0]        j_ff, j_in;
   logic [ADDR_W-1:0] fill_addr_ff, fill_addr_in;
   logic [7:0]        fill_val_ff, fill_val_in;
   logic              p_valid_ff, p_valid_in;
   logic [ADDR_W-1:0] p_addr_ff, p_addr_in;
   logic [7:0]        p_mask_ff, p_mask_in;
   logic              p_lit_ff, p_lit_in;
   logic [7:0]        res_rd_ff, res_rd_in;
   logic              res_status_ff, res_status_in;
   logic [7:0]        cursor_x_ff, cursor_x_in;
   logic [7:0]        cursor_y_ff, cursor_y_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_rd_ff, rsp_rd_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_cx_ff, rsp_cx_in;

   logic [7:0]        px;
   logic              on_panel;
   logic              pat_bit;

   assign px       = base_x_ff + 8'(j_ff);
   assign on_panel = ({1'b0, px} < 9'(PANEL_WIDTH)) && ({1'b0, py_ff} < 9'(PANEL_HEIGHT));
   assign pat_bit  = pattern_ff[~j_ff[3:0]];  // MSB is leftmost

   assign back_status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_rd_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_cursor_x_out = rsp_cx_ff;

   always_comb begin
      state_in      = state_ff;
      base_x_in     = base_x_ff;
      py_in         = py_ff;
      color_in      = color_ff;
      pattern_in    = pattern_ff;
      count_in      = count_ff;
      adv_in        = adv_ff;
      j_in          = j_ff;
      fill_addr_in  = fill_addr_ff;
      fill_val_in   = fill_val_ff;
      p_valid_in    = 1'b0;
      p_addr_in     = p_addr_ff;
      p_mask_in     = p_mask_ff;
      p_lit_in      = p_lit_ff;
      res_rd_in     = res_rd_ff;
      res_status_in = res_status_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_rd_in     = rsp_rd_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cx_in     = rsp_cx_ff;
      queue_pop     = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = frame_addr(head.x, head.y);

      unique case (state_ff) inside
         ST_CLEAR, ST_FILL: begin
            if (fill_addr_ff == ADDR_W'(STORE_SIZE - 1)) begin
               state_in = (state_ff == ST_CLEAR) ? ST_IDLE : ST_DONE;
            end else begin
               fill_addr_in = fill_addr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop     = 1'b1;
               res_rd_in     = 8'd0;
               res_status_in = 1'b0;
               unique case (head.op)
                  OP_FILL: begin
                     fill_addr_in = '0;
                     fill_val_in  = head.color ? FILL_ON : FILL_OFF;
                     state_in     = ST_FILL;
                  end
                  OP_PLOT: begin
                     base_x_in  = head.glyph ? cursor_x_ff : head.x;
                     py_in      = head.glyph ? cursor_y_ff + head.y : head.y;
                     color_in   = head.color;
                     pattern_in = head.pattern;
                     count_in   = head.count;
                     adv_in     = head.advance;
                     j_in       = 5'd0;
                     state_in   = ST_PLOT;
                  end
                  OP_CURSOR: begin
                     cursor_x_in = head.x;
                     cursor_y_in = head.y;
                     state_in    = ST_DONE;
                  end
                  OP_READ: begin
                     mem_re   = 1'b1;
                     state_in = ST_READ_WAIT;
                  end
                  OP_REJECT: begin
                     res_status_in = 1'b1;
                     state_in      = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_PLOT: begin
            // read of pixel j overlaps the write-back of pixel j-1
            if (j_ff != count_ff) begin
               mem_re     = on_panel;
               mem_raddr  = frame_addr(px, {3'd0, py_ff[7:3]});
               p_valid_in = on_panel;
               p_addr_in  = frame_addr(px, {3'd0, py_ff[7:3]});
               p_mask_in  = 8'd1 << py_ff[2:0];
               p_lit_in   = ~(pat_bit ^ color_ff);
               j_in       = j_ff + 5'd1;
            end else if (!p_valid_ff) begin
               if (adv_ff) begin
                  cursor_x_in = cursor_x_ff + 8'(count_ff);
               end
               state_in = ST_DONE;
            end
         end
         ST_READ_WAIT: begin
            res_rd_in = rd_data_ff;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_rd_in     = res_rd_ff;
               rsp_status_in = res_status_ff;
               rsp_cx_in     = cursor_x_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = p_addr_ff;
      mem_wdata = p_lit_ff ? (rd_data_ff | p_mask_ff) : (rd_data_ff & ~p_mask_ff);
      if (state_ff == ST_CLEAR || state_ff == ST_FILL) begin
         mem_we    = 1'b1;
         mem_waddr = fill_addr_ff;
         mem_wdata = fill_val_ff;
      end else if (p_valid_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         fill_addr_ff  <= '0;
         fill_val_ff   <= FILL_OFF;
         p_valid_ff    <= 1'b0;
         cursor_x_ff   <= 8'd0;
         cursor_y_ff   <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_addr_ff  <= fill_addr_in;
         fill_val_ff   <= fill_val_in;
         p_valid_ff    <= p_valid_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      base_x_ff     <= base_x_in;
      py_ff         <= py_in;
      color_ff      <= color_in;
      pattern_ff    <= pattern_in;
      count_ff      <= count_in;
      adv_ff        <= adv_in;
      j_ff          <= j_in;
      p_addr_ff     <= p_addr_in;
      p_mask_ff     <= p_mask_in;
      p_lit_ff      <= p_lit_in;
      res_rd_ff     <= res_rd_in;
      res_status_ff <= res_status_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cx_ff     <= rsp_cx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

endmodule

[hw/rtl/mono_framebuffer_text_engine_core.sv]
// ----------------------------------------------------------------------------
// mono_framebuffer_text_engine_core
// 128x64 page-packed monochrome framebuffer with a text cursor.
//
// Request channel (req_*): valid/stall. One request is one action: fill,
// draw pixel, set cursor, draw glyph row or read one page byte. Every
// request returns exactly one response on rsp_* (valid/stall), in order.
// csr_* writes font_width (index 0) and font_height (index 1); csr_ready is
// always high, writes are expected only while the engine is idle.
// font_width is capped at 16 for glyph rows; a glyph row does one
// read-modify-write per pixel, pipelined on one read and one write port,
// and pixels off the panel are clipped. A fill writes one frame store byte
// per cycle. Commands pass through the two-entry command queue. The back
// end works on one command at a time; the front end keeps accepting while
// the queue has room, and a finished response waits in the output register
// when rsp_stall is high. After reset the frame store is cleared, during
// which req_stall stays high.
// ----------------------------------------------------------------------------
module mono_framebuffer_text_engine_core
   import mfte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_x,
   input  logic [7:0]  req_y,
   input  logic        req_color,
   input  logic [7:0]  req_char_code,
   input  logic [3:0]  req_row_index,
   input  logic [15:0] req_row_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_status,
   output logic [7:0]  rsp_cursor_x_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);

   logic [4:0]      font_width_ff, font_width_in;
   logic [4:0]      font_height_ff, font_height_in;
   logic            cmd_push;
   cmd_type         cmd;
   cmd_type         head;
   logic            queue_empty;
   logic            queue_full;
   logic            queue_pop;
   back_status_type back_status;

   assign csr_ready = 1'b1;

   always_comb begin
      font_width_in  = font_width_ff;
      font_height_in = font_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FONT_WIDTH:  font_width_in  = csr_data;
            CSR_FONT_HEIGHT: font_height_in = csr_data;
            default:         font_width_in  = font_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_width_ff  <= FONT_W_RESET;
         font_height_ff <= FONT_H_RESET;
      end else begin
         font_width_ff  <= font_width_in;
         font_height_ff <= font_height_in;
      end
   end

   mfte_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_x         (req_x),
      .req_y         (req_y),
      .req_color     (req_color),
      .req_char_code (req_char_code),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .font_width    (font_width_ff),
      .font_height   (font_height_ff),
      .queue_full    (queue_full),
      .back_status   (back_status),
      .cmd_push      (cmd_push),
      .cmd           (cmd)
   );

   mfte_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (queue_pop),
      .head     (head),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   mfte_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .queue_empty      (queue_empty),
      .queue_pop        (queue_pop),
      .back_status      (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_cursor_x_out (rsp_cursor_x_out)
   );

endmodule

[sim/mono_framebuffer_text_engine_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_text_engine_core_tb
// Self-checking bench for the framebuffer text engine. A short directed table
// hits the corners (empty buffer after reset, panel clipping, rejected codes,
// cursor wrap, unused actions, fills). Random traffic then follows under
// eight font settings. Each response is checked against a shadow copy of the
// frame store, the cursor and the font registers, or against the fixed answer
// of a directed entry. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module mono_framebuffer_text_engine_core_tb
   import mfte_pkg::*;
();

   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
   localparam logic       ST_DONE       = 1'b0;
   localparam logic       ST_REJECT     = 1'b1;
   localparam int         NUM_PHASES    = 8;
   localparam int         PHASE_ITEMS   = 190;

   typedef struct {
      logic [2:0]  action;
      logic [7:0]  x;
      logic [7:0]  y;
      logic        color;
      logic [7:0]  code;
      logic [3:0]  row;
      logic [15:0] bits;
   } request_type;

   typedef struct {
      logic [7:0] data;
      logic       status;
      logic [7:0] cursor;
   } answer_type;

   typedef struct {
      request_type rq;
      bit          typed;
      answer_type  ans;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_action;
   logic [7:0]  req_x;
   logic [7:0]  req_y;
   logic        req_color;
   logic [7:0]  req_char_code;
   logic [3:0]  req_row_index;
   logic [15:0] req_row_bits;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_status;
   logic [7:0]  rsp_cursor_x_out;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [4:0]  csr_data;

   // shadow of the engine state
   logic [7:0] shadow_fb [STORE_SIZE] = '{default: 8'h00};
   logic [7:0] cur_x  = 8'd0;
   logic [7:0] cur_y  = 8'd0;
   logic [4:0] font_w = FONT_W_RESET;
   logic [4:0] font_h = FONT_H_RESET;

   answer_type answer_fifo [$];
   vector_type directed [$];
   answer_type no_answer;
   bit      quiet = 1'b0;
   int      glyph_row = 0;
   int      errors = 0;
   int      act_count [8] = '{default: 0};
   int      rejected = 0;

   mono_framebuffer_text_engine_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_x            (req_x),
      .req_y            (req_y),
      .req_color        (req_color),
      .req_char_code    (req_char_code),
      .req_row_index    (req_row_index),
      .req_row_bits     (req_row_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_cursor_x_out (rsp_cursor_x_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #(8_000_000);
      $display("mono_framebuffer_text_engine_core_tb NOT OK");
      $finish;
   end

   function automatic int idle_cycles();
      if (quiet || $urandom_range(0, 3) == 0)
         return 0;
      return int'($urandom_range(0, 16));
   endfunction

   function automatic void plot(int px, int py, logic lit);
      if (px < PANEL_WIDTH && py < PANEL_HEIGHT)
         shadow_fb[(py / 8) * PANEL_WIDTH + px][py % 8] = lit;
   endfunction

   // Applies one request to the shadow state and returns its response.
   function automatic answer_type exec_request(request_type rq);
      answer_type a;
      int fw;
      int fh;
      int py;
      a.data = 8'h00;
      a.status = ST_DONE;
      case (rq.action)
         ACT_FILL: begin
            foreach (shadow_fb[i])
               shadow_fb[i] = rq.color ? FILL_ON : FILL_OFF;
         end
         ACT_PIXEL: plot(int'(rq.x), int'(rq.y), rq.color);
         ACT_CURSOR: begin
            cur_x = rq.x;
            cur_y = rq.y;
         end
         ACT_GLYPH: begin
            if (rq.code < CHAR_FIRST || rq.code > CHAR_LAST) begin
               a.status = ST_REJECT;
            end else begin
               fw = int'((font_w > GLYPH_MAX) ? GLYPH_MAX : font_w);
               fh = int'((font_h > GLYPH_MAX) ? GLYPH_MAX : font_h);
               py = (int'(cur_y) + int'(rq.row)) & 255;
               for (int j = 0; j < fw; j++)
                  plot((int'(cur_x) + j) & 255, py, rq.bits[15 - j] ? rq.color : !rq.color);
               if (fh != 0 && int'(rq.row) == fh - 1)
                  cur_x = 8'(int'(cur_x) + fw);
            end
         end
         ACT_READ: begin
            if (rq.x < PANEL_WIDTH && rq.y < NUM_PAGES)
               a.data = shadow_fb[int'(rq.y) * PANEL_WIDTH + int'(rq.x)];
         end
         default: ;
      endcase
      a.cursor = cur_x;
      return a;
   endfunction

   function automatic vector_type vec(logic [2:0] act, int x, int y, bit color, int code,
                                      int rowi, int bits);
      vector_type v;
      v.rq.action = act;
      v.rq.x = 8'(x);
      v.rq.y = 8'(y);
      v.rq.color = color;
      v.rq.code = 8'(code);
      v.rq.row = 4'(rowi);
      v.rq.bits = 16'(bits);
      v.typed = 1'b0;
      v.ans = '{default: '0};
      return v;
   endfunction

   function automatic vector_type chk(vector_type v, logic [7:0] data, logic status,
                                      logic [7:0] cursor);
      v.typed = 1'b1;
      v.ans.data = data;
      v.ans.status = status;
      v.ans.cursor = cursor;
      return v;
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int pick;
      int fh_eff;
      pick = int'($urandom_range(0, 99));
      rq.x = 8'($urandom);
      rq.y = 8'($urandom);
      rq.color = 1'($urandom);
      rq.code = 8'($urandom);
      rq.row = 4'($urandom);
      rq.bits = 16'($urandom);
      fh_eff = int'((font_h > GLYPH_MAX) ? GLYPH_MAX : font_h);
      if (pick < 2) begin
         rq.action = ACT_FILL;
      end else if (pick < 22) begin
         rq.action = ACT_PIXEL;
         if ($urandom_range(0, 3) != 0) begin
            rq.x = 8'($urandom_range(0, PANEL_WIDTH - 1));
            rq.y = 8'($urandom_range(0, PANEL_HEIGHT - 1));
         end
      end else if (pick < 32) begin
         rq.action = ACT_CURSOR;
         if ($urandom_range(0, 3) != 0) begin
            rq.x = 8'($urandom_range(0, PANEL_WIDTH - 1));
            rq.y = 8'($urandom_range(0, PANEL_HEIGHT - 1));
         end
      end else if (pick < 72) begin
         rq.action = ACT_GLYPH;
         if ($urandom_range(0, 6) != 0)
            rq.code = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
         // mostly walk the rows of a glyph in order so the last row comes up
         if (fh_eff != 0 && $urandom_range(0, 3) != 0) begin
            rq.row = 4'(glyph_row % fh_eff);
            glyph_row = (glyph_row + 1) % fh_eff;
         end
      end else if (pick < 96) begin
         rq.action = ACT_READ;
         if ($urandom_range(0, 7) != 0) begin
            rq.x = 8'($urandom_range(0, PANEL_WIDTH - 1));
            rq.y = 8'($urandom_range(0, NUM_PAGES - 1));
         end
      end else begin
         rq.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      return rq;
   endfunction

   // Called at a clock edge; leaves req_valid high after acceptance.
   task automatic send(input request_type rq, input bit typed, input answer_type ans);
      int gap;
      answer_type model;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= rq.action;
      req_x         <= rq.x;
      req_y         <= rq.y;
      req_color     <= rq.color;
      req_char_code <= rq.code;
      req_row_index <= rq.row;
      req_row_bits  <= rq.bits;
      do @(posedge clock); while (req_stall);
      model = exec_request(rq);
      answer_fifo.push_back(typed ? ans : model);
      act_count[rq.action]++;
      if (model.status == ST_REJECT)
         rejected++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (answer_fifo.size() != 0)
         @(posedge clock);
   endtask

   task automatic configure(input logic [4:0] w, input logic [4:0] h);
      csr_valid <= 1'b1;
      csr_index <= CSR_FONT_WIDTH;
      csr_data  <= w;
      do @(posedge clock); while (!csr_ready);
      font_w = w;
      csr_index <= CSR_FONT_HEIGHT;
      csr_data  <= h;
      do @(posedge clock); while (!csr_ready);
      font_h = h;
      csr_valid <= 1'b0;
   endtask

   // response side stall: after each accepted response hold off for a random gap, which may be empty
   always @(posedge clock) begin : rsp_pacer
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         n = 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = idle_cycles();
         rsp_stall <= (n != 0);
      end else if (n > 1) begin
         n = n - 1;
      end else begin
         n = 0;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_check
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_fifo.size() == 0) begin
            $error("unexpected response: read_data %h status %b cursor_x_out %h",
                   rsp_read_data, rsp_status, rsp_cursor_x_out);
            errors++;
         end else begin
            want = answer_fifo.pop_front();
            if (rsp_read_data !== want.data) begin
               $error("read_data: expected %h, got %h", want.data, rsp_read_data);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %b, got %b", want.status, rsp_status);
               errors++;
            end
            if (rsp_cursor_x_out !== want.cursor) begin
               $error("cursor_x_out: expected %h, got %h", want.cursor, rsp_cursor_x_out);
               errors++;
            end
         end
      end
   end

   initial begin
      int phase_w [NUM_PHASES] = '{1, 16, 0, 31, 16, 17, 7, 0};
      int phase_h [NUM_PHASES] = '{1, 16, 0, 31, 0, 5, 10, 0};
      req_valid     <= 1'b0;
      req_action    <= ACT_FILL;
      req_x         <= '0;
      req_y         <= '0;
      req_color     <= 1'b0;
      req_char_code <= '0;
      req_row_index <= '0;
      req_row_bits  <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_FONT_WIDTH;
      csr_data      <= '0;
      no_answer = '{default: '0};

      // reset font: width 7, height 10
      directed.push_back(chk(vec(ACT_READ, 0, 0, 0, 0, 0, 0), 8'h00, ST_DONE, 8'd0));
      directed.push_back(chk(vec(ACT_READ, 127, 7, 0, 0, 0, 0), 8'h00, ST_DONE, 8'd0));
      directed.push_back(chk(vec(ACT_PIXEL, 0, 0, 1, 0, 0, 0), 8'h00, ST_DONE, 8'd0));
      directed.push_back(chk(vec(ACT_PIXEL, 127, 63, 1, 0, 0, 0), 8'h00, ST_DONE, 8'd0));
      // clipped pixels
      directed.push_back(chk(vec(ACT_PIXEL, 128, 5, 1, 0, 0, 0), 8'h00, ST_DONE, 8'd0));
      directed.push_back(chk(vec(ACT_PIXEL, 3, 64, 1, 0, 0, 0), 8'h00, ST_DONE, 8'd0));
      directed.push_back(chk(vec(ACT_READ, 0, 0, 0, 0, 0, 0), 8'h01, ST_DONE, 8'd0));
      directed.push_back(chk(vec(ACT_READ, 127, 7, 0, 0, 0, 0), 8'h80, ST_DONE, 8'd0));
      // reads off the store
      directed.push_back(chk(vec(ACT_READ, 128, 0, 0, 0, 0, 0), 8'h00, ST_DONE, 8'd0));
      directed.push_back(chk(vec(ACT_READ, 0, 8, 0, 0, 0, 0), 8'h00, ST_DONE, 8'd0));
      // codes outside the printable range
      directed.push_back(chk(vec(ACT_GLYPH, 0, 0, 1, CHAR_FIRST - 1, 0, 16'hFFFF),
                             8'h00, ST_REJECT, 8'd0));
      directed.push_back(chk(vec(ACT_GLYPH, 0, 0, 1, CHAR_LAST + 1, 9, 16'hFFFF),
                             8'h00, ST_REJECT, 8'd0));
      directed.push_back(chk(vec(ACT_GLYPH, 0, 0, 1, 0, 9, 16'hFFFF), 8'h00, ST_REJECT, 8'd0));
      directed.push_back(chk(vec(ACT_GLYPH, 0, 0, 1, 255, 9, 16'hFFFF), 8'h00, ST_REJECT, 8'd0));
      directed.push_back(chk(vec(ACT_CURSOR, 120, 60, 0, 0, 0, 0), 8'h00, ST_DONE, 8'd120));
      directed.push_back(chk(vec(ACT_GLYPH, 0, 0, 1, CHAR_FIRST, 0, 16'hFFFF),
                             8'h00, ST_DONE, 8'd120));
      directed.push_back(chk(vec(ACT_GLYPH, 0, 0, 0, CHAR_LAST, 9, 16'hA5A5),
                             8'h00, ST_DONE, 8'd127));
      // row past the font height: drawn, no advance
      directed.push_back(vec(ACT_GLYPH, 0, 0, 1, "A", 15, PIXEL_PATTERN));
      directed.push_back(vec(ACT_READ, 122, 7, 0, 0, 0, 0));
      // cursor advance wraps past 255
      directed.push_back(chk(vec(ACT_CURSOR, 250, 255, 0, 0, 0, 0), 8'h00, ST_DONE, 8'd250));
      directed.push_back(chk(vec(ACT_GLYPH, 0, 0, 1, "A", 9, 16'h0000), 8'h00, ST_DONE, 8'd1));
      directed.push_back(vec(ACT_READ, 0, 1, 0, 0, 0, 0));
      directed.push_back(chk(vec(ACT_UNUSED_LO, 5, 5, 1, "B", 3, 16'h1234),
                             8'h00, ST_DONE, 8'd1));
      directed.push_back(chk(vec(ACT_UNUSED_HI, 255, 255, 1, 255, 15, 16'hFFFF),
                             8'h00, ST_DONE, 8'd1));
      directed.push_back(chk(vec(ACT_FILL, 0, 0, 1, 0, 0, 0), 8'h00, ST_DONE, 8'd1));
      directed.push_back(chk(vec(ACT_READ, 64, 3, 0, 0, 0, 0), 8'hFF, ST_DONE, 8'd1));
      directed.push_back(chk(vec(ACT_FILL, 0, 0, 0, 0, 0, 0), 8'h00, ST_DONE, 8'd1));
      directed.push_back(chk(vec(ACT_READ, 127, 7, 0, 0, 0, 0), 8'h00, ST_DONE, 8'd1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send(directed[i].rq, directed[i].typed, directed[i].ans);

      phase_w[NUM_PHASES - 1] = int'($urandom_range(0, 31));
      phase_h[NUM_PHASES - 1] = int'($urandom_range(0, 31));
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         configure(5'(phase_w[phase]), 5'(phase_h[phase]));
         quiet = (phase % 3 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 63) == 0)
               settle();
            send(random_request(), 1'b0, no_answer);
         end
      end
      settle();
      repeat (40) @(posedge clock);

      $display("%0d fills, %0d pixels, %0d cursor moves, %0d glyph rows (%0d rejected),",
               act_count[ACT_FILL], act_count[ACT_PIXEL], act_count[ACT_CURSOR],
               act_count[ACT_GLYPH], rejected);
      $display("%0d page reads, %0d unused actions over %0d font settings",
               act_count[ACT_READ],
               act_count[ACT_UNUSED_LO] + act_count[ACT_UNUSED_LO + 1] +
               act_count[ACT_UNUSED_HI], NUM_PHASES + 1);
      if (errors == 0)
         $display("mono_framebuffer_text_engine_core_tb OK");
      else
         $display("mono_framebuffer_text_engine_core_tb NOT OK");
      $finish;
   end

endmodule
